/* rtl/positional_list_insert_delete_defines.svh */
// Assertion macros for the positional list block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH

`ifndef SYNTH

// Check a property on every rising edge outside reset.
`define PLID_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define PLID_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PLID_ASSERT(lbl, clk, rst_n, prop, msg)
`define PLID_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/plid_pkg.sv */
// Shared types and constants of the positional list block.
// No dependencies; imported by the cell, the controller and the top level.
package plid_pkg;

  localparam int DATA_W = 32;

  // Operation codes of the command channel
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_DUMP   = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Move broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

endpackage

/* rtl/plid_cell.sv */
// One storage cell of the list chain: holds one entry and moves data to or
// from its neighbors. Depends on plid_pkg.
module plid_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                        clk,
  input  plid_pkg::cell_op_t          op,
  input  logic [CNT_W-1:0]            pos,
  input  logic [CNT_W-1:0]            cnt,
  input  logic [plid_pkg::DATA_W-1:0] ins_val,
  input  logic [plid_pkg::DATA_W-1:0] left_val,
  input  logic [plid_pkg::DATA_W-1:0] right_val,
  input  logic [plid_pkg::DATA_W-1:0] head_val,
  output logic [plid_pkg::DATA_W-1:0] val
);
  import plid_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  // Pick the new content from the broadcast move and this cell's place
  always_comb begin
    data_nxt = data_r;
    case (op)
      OP_INSERT: begin
        if (MY_IDX == pos) begin
          data_nxt = ins_val;
        end else if (MY_IDX > pos) begin
          data_nxt = left_val;
        end
      end
      OP_DELETE: begin
        if (MY_IDX >= pos) begin
          data_nxt = right_val;
        end
      end
      OP_ROTATE: begin
        if (MY_NEXT == cnt) begin
          data_nxt = head_val;
        end else if (MY_NEXT < cnt) begin
          data_nxt = right_val;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  // Hold the entry
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign val = data_r;

endmodule

/* rtl/plid_ctrl.sv */
// Command decoder, entry count and result registers of the positional list.
// Depends on plid_pkg and positional_list_insert_delete_defines.svh.
`include "positional_list_insert_delete_defines.svh"

module plid_ctrl #(
  parameter int CAPACITY = 16,
  parameter int CNT_W    = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  plid_pkg::mode_t             in_mode,
  input  logic [CNT_W-1:0]            in_position,
  input  logic [plid_pkg::DATA_W-1:0] head_val,
  output plid_pkg::cell_op_t          cell_op,
  output logic [CNT_W-1:0]            cell_cnt,
  output logic                        out_valid,
  output plid_pkg::status_t           out_status,
  output logic [plid_pkg::DATA_W-1:0] out_entry_value,
  output logic [CNT_W-1:0]            out_entry_count,
  output logic                        out_list_empty,
  output logic                        out_last
);
  import plid_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              valid_r, valid_nxt;
  logic              last_r, last_nxt;
  status_t           status_r, status_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic [CNT_W-1:0]  ecount_r, ecount_nxt;
  logic              empty_r, empty_nxt;
  logic              accept;
  logic              dump_last;

  assign busy      = (state_r == S_DUMP);
  assign accept    = start && !busy;
  assign dump_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign cell_cnt  = count_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_mode == MODE_DUMP && count_r != '0) begin
          state_nxt = S_DUMP;
        end
      end
      S_DUMP: begin
        if (dump_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Cell moves, count update and result beat
  always_comb begin
    cell_op    = OP_HOLD;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    valid_nxt  = 1'b0;
    last_nxt   = 1'b0;
    status_nxt = ST_OK;
    value_nxt  = '0;
    empty_nxt  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          valid_nxt = 1'b1;
          last_nxt  = 1'b1;
          case (in_mode)
            MODE_INSERT: begin
              if (in_position > count_r) begin
                status_nxt = ST_RANGE;
              end else if (count_r == CAP_CNT) begin
                status_nxt = ST_FULL;
              end else begin
                cell_op   = OP_INSERT;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            MODE_DELETE: begin
              if (in_position >= count_r) begin
                status_nxt = ST_RANGE;
              end else begin
                cell_op   = OP_DELETE;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            MODE_CLEAR: begin
              count_nxt = '0;
            end
            MODE_DUMP: begin
              if (count_r == '0) begin
                empty_nxt = 1'b1;
              end else begin
                valid_nxt = 1'b0;
                last_nxt  = 1'b0;
                idx_nxt   = '0;
              end
            end
            default: valid_nxt = 1'b1;
          endcase
        end
      end
      S_DUMP: begin
        // Emit the head and rotate the live entries by one
        cell_op   = OP_ROTATE;
        valid_nxt = 1'b1;
        last_nxt  = dump_last;
        value_nxt = head_val;
        idx_nxt   = idx_r + IDX_W'(1);
      end
      default: cell_op = OP_HOLD;
    endcase
    ecount_nxt = count_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    value_r  <= value_nxt;
    ecount_r <= ecount_nxt;
    empty_r  <= empty_nxt;
  end

  assign out_valid       = valid_r;
  assign out_last        = last_r;
  assign out_status      = status_r;
  assign out_entry_value = value_r;
  assign out_entry_count = ecount_r;
  assign out_list_empty  = empty_r;

  `PLID_NEVER(a_count_cap, clk, rst_n, count_r > CAP_CNT, "entry count above capacity")
  `PLID_NEVER(a_dump_nonempty, clk, rst_n, busy && count_r == '0, "dump on an empty list")
  `PLID_ASSERT(a_mid_beat_in_dump, clk, rst_n, (valid_r && !last_r) |-> busy, "non-final beat outside a dump")
  `PLID_ASSERT(a_single_beat, clk, rst_n, (accept && in_mode != MODE_DUMP) |=> (valid_r && last_r), "missing single result beat")
  `PLID_NEVER(a_empty_count, clk, rst_n, valid_r && empty_r && ecount_r != '0, "empty mark with entries")

endmodule

/* rtl/positional_list_insert_delete.sv */
// Positional list of signed 32-bit values, up to CAPACITY entries, held in a
// chain of cells. Insert, delete and clear give one result beat in the next
// cycle; busy stays low, so a new command may follow at once. A dump of n
// entries keeps busy high while the chain rotates one entry per cycle past
// the head cell, giving one beat per cycle; a dump of an empty list gives one
// beat and leaves busy low. The receiver cannot stall: every beat shows on the
// out_ ports for exactly one cycle under out_valid. Depends on plid_pkg,
// plid_cell and plid_ctrl.
module positional_list_insert_delete #(
  parameter int CAPACITY = 16,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  plid_pkg::mode_t             in_mode,
  input  logic [CNT_W-1:0]            in_position,
  input  logic [plid_pkg::DATA_W-1:0] in_item_value,
  output logic                        out_valid,
  output plid_pkg::status_t           out_status,
  output logic [plid_pkg::DATA_W-1:0] out_entry_value,
  output logic [CNT_W-1:0]            out_entry_count,
  output logic                        out_list_empty,
  output logic                        out_last
);
  import plid_pkg::*;

  cell_op_t          cell_op;
  logic [CNT_W-1:0]  cell_cnt;
  logic [DATA_W-1:0] cell_val [CAPACITY];

  // Decode commands and drive result beats
  plid_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_position     (in_position),
    .head_val        (cell_val[0]),
    .cell_op         (cell_op),
    .cell_cnt        (cell_cnt),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_value (out_entry_value),
    .out_entry_count (out_entry_count),
    .out_list_empty  (out_list_empty),
    .out_last        (out_last)
  );

  // Build the chain; the ends see zero from outside
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_val;
    logic [DATA_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    plid_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .op        (cell_op),
      .pos       (in_position),
      .cnt       (cell_cnt),
      .ins_val   (in_item_value),
      .left_val  (left_val),
      .right_val (right_val),
      .head_val  (cell_val[0]),
      .val       (cell_val[i])
    );
  end

endmodule
